### hw/rtl/dense_graph_shortest_path_defines.svh
// Assertion macros shared by the shortest path block.
`ifndef DENSE_GRAPH_SHORTEST_PATH_DEFINES_SVH
`define DENSE_GRAPH_SHORTEST_PATH_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define DGSP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define DGSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/dgsp_pkg.sv
// Constants, types and helpers of the shortest path block.
package dgsp_pkg;

	localparam int MAX_VERTICES = 16;
	localparam int WEIGHT_BITS  = 16;

	localparam int VW            = $clog2(MAX_VERTICES);
	localparam int CNT_W         = $clog2(MAX_VERTICES + 1);
	localparam int DIST_BITS     = WEIGHT_BITS + VW;
	localparam int MAT_DEPTH     = MAX_VERTICES * MAX_VERTICES;
	localparam int MAT_AW        = $clog2(MAT_DEPTH);
	localparam int RESULT_LIMIT  = 16;
	localparam int K_W           = $clog2(RESULT_LIMIT);
	localparam int OUT_DIST_BITS = 20;
	localparam int WIDE_BITS     = (DIST_BITS > OUT_DIST_BITS) ? DIST_BITS : OUT_DIST_BITS;

	localparam logic [OUT_DIST_BITS-1:0] DIST_MAX = {OUT_DIST_BITS{1'b1}};
	localparam logic [4:0] VCOUNT_RESET = 5'd16;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// One entry of per-vertex search state
	typedef struct packed {
		logic                 known;
		logic                 settled;
		logic [DIST_BITS-1:0] cost;
		logic [VW-1:0]        pred;
	} vtx_entry_t;

	typedef struct packed {
		logic              rd_en;
		logic [VW-1:0]     rd_addr;
		logic              wr_en;
		logic [VW-1:0]     wr_addr;
		vtx_entry_t        wr_data;
	} vtx_req_t;

	typedef struct packed {
		logic                   rd_en;
		logic [MAT_AW-1:0]      rd_addr;
		logic                   wr_en;
		logic [MAT_AW-1:0]      wr_addr;
		logic                   wr_absent;
		logic [WEIGHT_BITS-1:0] wr_weight;
	} mat_req_t;

	typedef struct packed {
		logic                   present;
		logic [WEIGHT_BITS-1:0] weight;
	} mat_rsp_t;

	// Clip a path distance to the result field
	function automatic logic [OUT_DIST_BITS-1:0] sat_dist(input logic [DIST_BITS-1:0] d);
		logic [WIDE_BITS-1:0] wide;
		wide = WIDE_BITS'(d);
		if (wide > WIDE_BITS'(DIST_MAX))
			return DIST_MAX;
		return OUT_DIST_BITS'(wide);
	endfunction

endpackage

### hw/rtl/dgsp_ifs.sv
// Request and result channel interfaces of the shortest path block.
interface dgsp_req_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [3:0]  row;
	logic [3:0]  col;
	logic [15:0] weight;
	logic        absent;
	logic [3:0]  src;
	logic [3:0]  target;

	modport source (output valid, opcode, row, col, weight, absent, src, target,
		input ready);
	modport sink (input valid, opcode, row, col, weight, absent, src, target,
		output ready);
endinterface

interface dgsp_res_if;
	logic        valid;
	logic        ready;
	logic [3:0]  vertex;
	logic [19:0] distance;
	logic        reachable;
	logic        last;

	modport source (output valid, vertex, distance, reachable, last, input ready);
	modport sink (input valid, vertex, distance, reachable, last, output ready);
endinterface

### hw/rtl/dgsp_matrix_mem.sv
// Adjacency matrix memory with per-entry valid bits cleared at reset.
module dgsp_matrix_mem (
	input  logic              clk,
	input  logic              arst_n,
	input  dgsp_pkg::mat_req_t req,
	output dgsp_pkg::mat_rsp_t rsp
);

	logic [dgsp_pkg::WEIGHT_BITS:0] mem [dgsp_pkg::MAT_DEPTH];
	logic [dgsp_pkg::MAT_DEPTH-1:0] valid_q;
	logic [dgsp_pkg::WEIGHT_BITS:0] rd_data_q;
	logic                           rd_valid_q;

	// Mark entries written since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.wr_en) begin
			valid_q[req.wr_addr] <= 1'b1;
		end
	end

	// Store and read entries
	always_ff @(posedge clk) begin
		if (req.wr_en)
			mem[req.wr_addr] <= {req.wr_absent, req.wr_weight};
		if (req.rd_en) begin
			rd_data_q  <= mem[req.rd_addr];
			rd_valid_q <= valid_q[req.rd_addr];
		end
	end

	// An entry never written reads as absent
	assign rsp.present = rd_valid_q && !rd_data_q[dgsp_pkg::WEIGHT_BITS];
	assign rsp.weight  = rd_data_q[dgsp_pkg::WEIGHT_BITS-1:0];

endmodule

### hw/rtl/dgsp_vertex_mem.sv
// Per-vertex search state memory: distance, known, settled, predecessor.
module dgsp_vertex_mem (
	input  logic                clk,
	input  dgsp_pkg::vtx_req_t  req,
	output dgsp_pkg::vtx_entry_t rd_data
);

	dgsp_pkg::vtx_entry_t mem [dgsp_pkg::MAX_VERTICES];

	// Write and read one entry each cycle
	always_ff @(posedge clk) begin
		if (req.wr_en)
			mem[req.wr_addr] <= req.wr_data;
		if (req.rd_en)
			rd_data <= mem[req.rd_addr];
	end

endmodule

### hw/rtl/dgsp_seq.sv
// Query sequencer: init, min scan, settle, row relax and path walk.
module dgsp_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [4:0]            cfg_wr_data,
	dgsp_req_if.sink              request,
	dgsp_res_if.source            result,
	output dgsp_pkg::mat_req_t    mat_req,
	input  dgsp_pkg::mat_rsp_t    mat_rsp,
	output dgsp_pkg::vtx_req_t    vtx_req,
	input  dgsp_pkg::vtx_entry_t  vtx_rd
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_INIT, ST_SCAN, ST_SETTLE, ST_RELAX, ST_EMIT, ST_PATH_RD, ST_PATH_LD
	} state_t;

	state_t                             state_q;
	logic [4:0]                         vcount_q;
	logic [dgsp_pkg::CNT_W-1:0]         n_q;
	logic [dgsp_pkg::CNT_W-1:0]         idx_q;
	logic [dgsp_pkg::VW-1:0]            src_q;
	logic [dgsp_pkg::VW-1:0]            tgt_q;
	logic [3:0]                         tgt_raw_q;
	logic                               rd_v_s1;
	logic [dgsp_pkg::VW-1:0]            rd_idx_s1;
	logic                               best_have_q;
	logic                               best_known_q;
	logic [dgsp_pkg::DIST_BITS-1:0]     best_dist_q;
	logic [dgsp_pkg::VW-1:0]            best_q;
	logic [dgsp_pkg::VW-1:0]            best_pred_q;
	logic [dgsp_pkg::VW-1:0]            m_q;
	logic [dgsp_pkg::DIST_BITS-1:0]     m_dist_q;
	logic [dgsp_pkg::DIST_BITS-1:0]     tgt_dist_q;
	logic                               reach_q;
	logic [dgsp_pkg::VW-1:0]            cur_q;
	logic [dgsp_pkg::K_W-1:0]           k_q;
	logic                               out_valid_q;
	logic [3:0]                         out_vertex_q;
	logic [dgsp_pkg::OUT_DIST_BITS-1:0] out_dist_q;
	logic                               out_reach_q;
	logic                               out_last_q;

	logic                               req_acc;
	logic [dgsp_pkg::CNT_W-1:0]         n_cfg;
	logic                               out_free;
	logic                               take;
	logic                               upd;
	logic                               fin;
	logic [dgsp_pkg::DIST_BITS-1:0]     cand;

	assign request.ready = (state_q == ST_IDLE);
	assign req_acc       = request.valid && request.ready;
	assign out_free      = !out_valid_q || result.ready;

	assign result.valid     = out_valid_q;
	assign result.vertex    = out_vertex_q;
	assign result.distance  = out_dist_q;
	assign result.reachable = out_reach_q;
	assign result.last      = out_last_q;

	// Clamp the configured vertex count
	always_comb begin
		if (vcount_q == 5'd0)
			n_cfg = dgsp_pkg::CNT_W'(1);
		else if (32'(vcount_q) > dgsp_pkg::MAX_VERTICES)
			n_cfg = dgsp_pkg::CNT_W'(dgsp_pkg::MAX_VERTICES);
		else
			n_cfg = dgsp_pkg::CNT_W'(vcount_q);
	end

	// Scan: keep the unsettled vertex of least distance, highest index on ties
	assign take = rd_v_s1 && !vtx_rd.settled &&
		(!best_have_q || (vtx_rd.known ? (!best_known_q || vtx_rd.cost <= best_dist_q)
			: !best_known_q));

	// Relax: candidate through the vertex just settled
	assign cand = m_dist_q + dgsp_pkg::DIST_BITS'(mat_rsp.weight);
	assign upd  = rd_v_s1 && !vtx_rd.settled && mat_rsp.present &&
		(!vtx_rd.known || cand < vtx_rd.cost);

	assign fin = !reach_q || (cur_q == src_q) ||
		(k_q == dgsp_pkg::K_W'(dgsp_pkg::RESULT_LIMIT - 1));

	// Drive memory ports from state
	always_comb begin
		mat_req = '0;
		vtx_req = '0;
		mat_req.wr_en = req_acc && (request.opcode == dgsp_pkg::OP_WRITE) &&
			(32'(request.row) < dgsp_pkg::MAX_VERTICES) &&
			(32'(request.col) < dgsp_pkg::MAX_VERTICES);
		mat_req.wr_addr = dgsp_pkg::MAT_AW'(dgsp_pkg::VW'(request.row)) *
			dgsp_pkg::MAT_AW'(dgsp_pkg::MAX_VERTICES) +
			dgsp_pkg::MAT_AW'(dgsp_pkg::VW'(request.col));
		mat_req.wr_absent = request.absent;
		mat_req.wr_weight = dgsp_pkg::WEIGHT_BITS'(request.weight);
		case (state_q)
			ST_INIT: begin
				vtx_req.wr_en         = 1'b1;
				vtx_req.wr_addr       = idx_q[dgsp_pkg::VW-1:0];
				vtx_req.wr_data.known = (idx_q[dgsp_pkg::VW-1:0] == src_q);
			end
			ST_SCAN: begin
				vtx_req.rd_en   = (idx_q != n_q);
				vtx_req.rd_addr = idx_q[dgsp_pkg::VW-1:0];
			end
			ST_SETTLE: begin
				vtx_req.wr_en           = 1'b1;
				vtx_req.wr_addr         = best_q;
				vtx_req.wr_data.known   = best_known_q;
				vtx_req.wr_data.settled = 1'b1;
				vtx_req.wr_data.cost    = best_dist_q;
				vtx_req.wr_data.pred    = best_pred_q;
			end
			ST_RELAX: begin
				vtx_req.rd_en   = (idx_q != n_q);
				vtx_req.rd_addr = idx_q[dgsp_pkg::VW-1:0];
				mat_req.rd_en   = (idx_q != n_q);
				mat_req.rd_addr = dgsp_pkg::MAT_AW'(m_q) *
					dgsp_pkg::MAT_AW'(dgsp_pkg::MAX_VERTICES) +
					dgsp_pkg::MAT_AW'(idx_q[dgsp_pkg::VW-1:0]);
				vtx_req.wr_en         = upd;
				vtx_req.wr_addr       = rd_idx_s1;
				vtx_req.wr_data.known = 1'b1;
				vtx_req.wr_data.cost  = cand;
				vtx_req.wr_data.pred  = m_q;
			end
			ST_PATH_RD: begin
				vtx_req.rd_en   = 1'b1;
				vtx_req.rd_addr = cur_q;
			end
			default: begin
			end
		endcase
	end

	// Hold state, counters and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			vcount_q     <= dgsp_pkg::VCOUNT_RESET;
			n_q          <= '0;
			idx_q        <= '0;
			src_q        <= '0;
			tgt_q        <= '0;
			tgt_raw_q    <= '0;
			rd_v_s1      <= 1'b0;
			rd_idx_s1    <= '0;
			best_have_q  <= 1'b0;
			best_known_q <= 1'b0;
			best_dist_q  <= '0;
			best_q       <= '0;
			best_pred_q  <= '0;
			m_q          <= '0;
			m_dist_q     <= '0;
			tgt_dist_q   <= '0;
			reach_q      <= 1'b0;
			cur_q        <= '0;
			k_q          <= '0;
			out_valid_q  <= 1'b0;
			out_vertex_q <= '0;
			out_dist_q   <= '0;
			out_reach_q  <= 1'b0;
			out_last_q   <= 1'b0;
		end else begin
			if (cfg_wr_en)
				vcount_q <= cfg_wr_data;
			// Drop a taken result unless the emit state loads the next one
			if (result.ready && state_q != ST_EMIT)
				out_valid_q <= 1'b0;
			rd_v_s1   <= vtx_req.rd_en && (state_q != ST_PATH_RD);
			rd_idx_s1 <= idx_q[dgsp_pkg::VW-1:0];
			case (state_q)
				ST_IDLE: begin
					if (req_acc && request.opcode == dgsp_pkg::OP_QUERY) begin
						n_q       <= n_cfg;
						idx_q     <= '0;
						src_q     <= dgsp_pkg::VW'(request.src);
						tgt_q     <= dgsp_pkg::VW'(request.target);
						tgt_raw_q <= request.target;
						k_q       <= '0;
						if (32'(request.src) >= 32'(n_cfg) ||
							32'(request.target) >= 32'(n_cfg)) begin
							reach_q <= 1'b0;
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_INIT;
						end
					end
				end
				ST_INIT: begin
					if (idx_q == n_q - dgsp_pkg::CNT_W'(1)) begin
						idx_q       <= '0;
						best_have_q <= 1'b0;
						state_q     <= ST_SCAN;
					end else begin
						idx_q <= idx_q + dgsp_pkg::CNT_W'(1);
					end
				end
				ST_SCAN: begin
					if (idx_q != n_q)
						idx_q <= idx_q + dgsp_pkg::CNT_W'(1);
					if (take) begin
						best_have_q  <= 1'b1;
						best_q       <= rd_idx_s1;
						best_known_q <= vtx_rd.known;
						best_dist_q  <= vtx_rd.cost;
						best_pred_q  <= vtx_rd.pred;
					end
					if (idx_q == n_q && rd_v_s1)
						state_q <= ST_SETTLE;
				end
				ST_SETTLE: begin
					idx_q    <= '0;
					m_q      <= best_q;
					m_dist_q <= best_dist_q;
					// Target settled, or nothing reachable remains
					if (best_q == tgt_q || !best_known_q) begin
						reach_q    <= best_known_q;
						tgt_dist_q <= best_dist_q;
						cur_q      <= tgt_q;
						state_q    <= ST_EMIT;
					end else begin
						state_q <= ST_RELAX;
					end
				end
				ST_RELAX: begin
					if (idx_q != n_q)
						idx_q <= idx_q + dgsp_pkg::CNT_W'(1);
					if (idx_q == n_q && rd_v_s1) begin
						idx_q       <= '0;
						best_have_q <= 1'b0;
						state_q     <= ST_SCAN;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_vertex_q <= reach_q ? 4'(cur_q) : tgt_raw_q;
						out_dist_q   <= reach_q ? dgsp_pkg::sat_dist(tgt_dist_q) : '0;
						out_reach_q  <= reach_q;
						out_last_q   <= fin;
						state_q      <= fin ? ST_IDLE : ST_PATH_RD;
					end
				end
				ST_PATH_RD: begin
					state_q <= ST_PATH_LD;
				end
				ST_PATH_LD: begin
					cur_q   <= vtx_rd.pred;
					k_q     <= k_q + dgsp_pkg::K_W'(1);
					state_q <= ST_EMIT;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### hw/rtl/dense_graph_shortest_path.sv
// Shortest path block over a dense adjacency matrix, top level.
// A write item stores one matrix entry and gives no result. A query item runs
// Dijkstra from source until target is settled or no reachable vertex remains
// (a source or target out of range gives an unreachable result at once): the
// vertex-state memory is set up over N entries (N = active vertex count), then
// each settled vertex costs one min-scan pass, one settle step and one relax
// pass over its matrix row (the target needs no relax pass); each further path
// vertex goes through the predecessor read. The rate is set by the single read
// port of the vertex-state memory, which both passes sweep one entry a cycle.
// The matrix reads as absent after reset through per-entry valid bits, so no
// clearing pass runs. A new item is taken while the last result still waits.
`include "dense_graph_shortest_path_defines.svh"

module dense_graph_shortest_path (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [4:0] cfg_wr_data,
	dgsp_req_if.sink   request,
	dgsp_res_if.source result
);

	dgsp_pkg::mat_req_t   mat_req;
	dgsp_pkg::mat_rsp_t   mat_rsp;
	dgsp_pkg::vtx_req_t   vtx_req;
	dgsp_pkg::vtx_entry_t vtx_rd;

	// Sequencer
	dgsp_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.request     (request),
		.result      (result),
		.mat_req     (mat_req),
		.mat_rsp     (mat_rsp),
		.vtx_req     (vtx_req),
		.vtx_rd      (vtx_rd)
	);

	// Edge weights
	dgsp_matrix_mem u_matrix (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mat_req),
		.rsp    (mat_rsp)
	);

	// Search state
	dgsp_vertex_mem u_vertex (
		.clk     (clk),
		.req     (vtx_req),
		.rd_data (vtx_rd)
	);

	// A query item makes the block busy
	`DGSP_ASSERT_NEXT(a_query_busy, clk, arst_n, request.valid && request.ready && request.opcode == dgsp_pkg::OP_QUERY, !request.ready, "query item accepted but block still ready")

	// Matrix writes only happen while no search reads the matrix
	`DGSP_ASSERT_NOW(a_mat_excl, clk, arst_n, mat_req.wr_en, !mat_req.rd_en, "matrix written during a relax pass")

	// Read-modify-write of the vertex state never overlaps on one entry
	`DGSP_ASSERT_NOW(a_vtx_overlap, clk, arst_n, vtx_req.wr_en && vtx_req.rd_en, vtx_req.wr_addr != vtx_req.rd_addr, "vertex entry read and written in one cycle")

endmodule
